### sv/pushdown_automaton_recognizer_top_defines.svh
// Assertion helpers for the pushdown automaton recognizer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PUSHDOWN_AUTOMATON_RECOGNIZER_TOP_DEFINES_SVH
`define PUSHDOWN_AUTOMATON_RECOGNIZER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pda_pkg.sv
package pda_pkg;

    // Sizing of the automaton.
    localparam int TABLE_DEPTH = 32;
    localparam int STACK_DEPTH = 64;
    localparam int STATE_COUNT = 16;
    localparam int MAX_PUSH    = 4;
    localparam int QUEUE_DEPTH = 2;

    // Derived widths and limits.
    localparam int PUSH_FIELDS = 4;
    localparam int PUSH_LIMIT  = (MAX_PUSH < PUSH_FIELDS) ? MAX_PUSH : PUSH_FIELDS;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Special symbols.
    localparam logic [7:0] NO_SYMBOL   = 8'd126;
    localparam logic [7:0] BOTTOM_MARK = 8'd90;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_FEED  = 2'd2;

    // Result status codes.
    localparam logic [2:0] STATUS_RUN    = 3'd0;
    localparam logic [2:0] STATUS_ACCEPT = 3'd1;
    localparam logic [2:0] STATUS_REJECT = 3'd2;
    localparam logic [2:0] STATUS_OVERFL = 3'd3;
    localparam logic [2:0] STATUS_EMPTY  = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] entry_index;
        logic [3:0] from_state;
        logic [3:0] to_state;
        logic [7:0] in_symbol;
        logic [7:0] pop_symbol;
        logic [7:0] push_first;
        logic [7:0] push_second;
        logic [7:0] push_third;
        logic [7:0] push_fourth;
        logic       last_symbol;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] current_state;
        logic [7:0] stack_top;
        logic [6:0] stack_depth;
    } result_t;

    // One transition rule; push[0] is pushed first.
    typedef struct packed {
        logic [3:0]                  from_state;
        logic [3:0]                  to_state;
        logic [7:0]                  sym;
        logic [7:0]                  need_top;
        logic [PUSH_FIELDS-1:0][7:0] push;
    } rule_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_START,
        CMD_FEED
    } cmd_kind_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [4:0] entry_index;
        rule_t      rule;
        logic       last;
    } cmd_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_EXEC,
        BS_SELECT,
        BS_APPLY,
        BS_PUSH,
        BS_FETCH,
        BS_FILL,
        BS_FINISH,
        BS_REPORT
    } back_state_t;

endpackage

### sv/pda_front.sv
module pda_front (
    input  logic          start,
    input  pda_pkg::item_t item,
    input  logic          q_full,
    output logic          q_push,
    output pda_pkg::cmd_t  cmd
);
    import pda_pkg::*;

    logic load_ok;

    // A load is kept only when its index and both states are in range.
    assign load_ok = ({1'b0, item.entry_index} < (TABLE_DEPTH))
                  && ({1'b0, item.from_state} < (STATE_COUNT))
                  && ({1'b0, item.to_state} < (STATE_COUNT));

    // Every accepted item becomes one queue entry.
    assign q_push = start && !q_full;

    // Classify the item and pack its payload for the back end.
    always_comb
    begin
        cmd.entry_index      = item.entry_index;
        cmd.rule.from_state  = item.from_state;
        cmd.rule.to_state    = item.to_state;
        cmd.rule.sym         = item.in_symbol;
        cmd.rule.need_top    = item.pop_symbol;
        cmd.rule.push[0]     = item.push_first;
        cmd.rule.push[1]     = item.push_second;
        cmd.rule.push[2]     = item.push_third;
        cmd.rule.push[3]     = item.push_fourth;
        cmd.last             = item.last_symbol;
        case (item.operation)
            OP_LOAD:  cmd.kind = load_ok ? CMD_LOAD : CMD_NOP;
            OP_START: cmd.kind = CMD_START;
            OP_FEED:  cmd.kind = CMD_FEED;
            default:  cmd.kind = CMD_NOP;
        endcase
    end

endmodule

### sv/pda_queue.sv
module pda_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pda_pkg::cmd_t  push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output pda_pkg::cmd_t  head_cmd
);
    import pda_pkg::*;

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == QC_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates, with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/pda_back.sv
module pda_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_data,
    input  logic            q_valid,
    input  pda_pkg::cmd_t    q_cmd,
    output logic            q_pop,
    output logic            done,
    output pda_pkg::result_t result
);
    import pda_pkg::*;

    back_state_t state_reg, state_next;

    // Configuration and automaton state.
    logic [3:0]             init_reg;
    cmd_t                   cmd_reg, cmd_next;
    logic [3:0]             mstate_reg, mstate_next;
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic [7:0]             top_reg, top_next;
    logic                   dead_reg, dead_next;
    logic [2:0]             status_reg, status_next;

    // Transition work registers.
    logic [TABLE_DEPTH-1:0] match_reg, match_next;
    logic [TBL_AW-1:0]      hit_idx_reg, hit_idx_next;
    logic                   hit_reg, hit_next;
    logic [PUSH_FIELDS-1:0][7:0] push_reg, push_next;
    logic [1:0]             k_reg, k_next;

    // Transition table with per-entry valid bits.
    rule_t                  table_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   tbl_we;

    // Symbol stack memory.
    logic [7:0]             stack_mem [STACK_DEPTH];
    logic                   stk_we;
    logic [STK_AW-1:0]      stk_waddr;
    logic [7:0]             stk_wdata;
    logic [STK_AW-1:0]      stk_raddr;
    logic [7:0]             rd_reg;

    // Combinational helpers.
    logic [TABLE_DEPTH-1:0] match_vec;
    rule_t                  hit_rule;
    logic [2:0]             push_cnt;
    logic [SP_W:0]          new_depth;
    logic [7:0]             cur_push;

    assign q_pop = (state_reg == BS_IDLE) && q_valid;
    assign done  = (state_reg == BS_REPORT);

    // Report the current automaton; the top reads as zero on an empty stack.
    always_comb
    begin
        result.status        = status_reg;
        result.current_state = mstate_reg;
        result.stack_top     = (sp_reg == '0) ? 8'd0 : top_reg;
        result.stack_depth   = 7'(sp_reg);
    end

    // Compare every table entry against state, fed symbol and stack top.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_vec[i] = valid_reg[i]
                        && (table_reg[i].from_state == mstate_reg)
                        && (table_reg[i].sym == cmd_reg.rule.sym)
                        && (table_reg[i].need_top == top_reg);
        end
    end

    // Count the push fields that carry a symbol, then check the stack bound.
    assign hit_rule = table_reg[hit_idx_reg];
    always_comb
    begin
        push_cnt = '0;
        for (int k = 0; k < PUSH_FIELDS; k++)
        begin
            if ((k < PUSH_LIMIT) && (hit_rule.push[k] != NO_SYMBOL))
            begin
                push_cnt = push_cnt + 3'd1;
            end
        end
        new_depth = {1'b0, sp_reg} - 1'b1 + (SP_W + 1)'(push_cnt);
    end

    assign cur_push  = push_reg[k_reg];
    assign stk_raddr = STK_AW'(sp_reg - 1'b1);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if ((cmd_reg.kind == CMD_FEED) && !dead_reg && (sp_reg != '0))
                begin
                    state_next = BS_SELECT;
                end
                else
                begin
                    state_next = BS_REPORT;
                end
            end
            BS_SELECT:
            begin
                state_next = BS_APPLY;
            end
            BS_APPLY:
            begin
                if (!hit_reg || (new_depth > (SP_W + 1)'(STACK_DEPTH)))
                begin
                    state_next = BS_REPORT;
                end
                else if (push_cnt == '0)
                begin
                    state_next = BS_FETCH;
                end
                else
                begin
                    state_next = BS_PUSH;
                end
            end
            BS_PUSH:
            begin
                if (k_reg == 2'(PUSH_LIMIT - 1))
                begin
                    state_next = BS_FINISH;
                end
            end
            BS_FETCH:
            begin
                state_next = (sp_reg == '0) ? BS_FINISH : BS_FILL;
            end
            BS_FILL:
            begin
                state_next = BS_FINISH;
            end
            BS_FINISH:
            begin
                state_next = BS_REPORT;
            end
            BS_REPORT:
            begin
                state_next = BS_IDLE;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Datapath updates and memory controls for each sequencer step.
    always_comb
    begin
        cmd_next     = cmd_reg;
        mstate_next  = mstate_reg;
        sp_next      = sp_reg;
        top_next     = top_reg;
        dead_next    = dead_reg;
        status_next  = status_reg;
        match_next   = match_reg;
        hit_idx_next = hit_idx_reg;
        hit_next     = hit_reg;
        push_next    = push_reg;
        k_next       = k_reg;
        valid_next   = valid_reg;
        tbl_we       = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = STK_AW'(sp_reg);
        stk_wdata    = cur_push;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                end
            end
            BS_EXEC:
            begin
                status_next = STATUS_RUN;
                match_next  = match_vec;
                case (cmd_reg.kind)
                    CMD_LOAD:
                    begin
                        tbl_we = 1'b1;
                        valid_next[TBL_AW'(cmd_reg.entry_index)] = 1'b1;
                    end
                    CMD_START:
                    begin
                        stk_we      = 1'b1;
                        stk_waddr   = '0;
                        stk_wdata   = BOTTOM_MARK;
                        sp_next     = SP_W'(1);
                        top_next    = BOTTOM_MARK;
                        mstate_next = ({1'b0, init_reg} < (STATE_COUNT)) ? init_reg : 4'd0;
                        dead_next   = 1'b0;
                    end
                    CMD_FEED:
                    begin
                        if (dead_reg)
                        begin
                            status_next = STATUS_REJECT;
                        end
                        else if (sp_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            dead_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_RUN;
                    end
                endcase
            end
            BS_SELECT:
            begin
                // Lowest matching index wins.
                hit_next     = |match_reg;
                hit_idx_next = '0;
                for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                begin
                    if (match_reg[i])
                    begin
                        hit_idx_next = TBL_AW'(i);
                    end
                end
            end
            BS_APPLY:
            begin
                k_next    = '0;
                push_next = hit_rule.push;
                if (!hit_reg)
                begin
                    status_next = STATUS_REJECT;
                    dead_next   = 1'b1;
                end
                else if (new_depth > (SP_W + 1)'(STACK_DEPTH))
                begin
                    status_next = STATUS_OVERFL;
                    dead_next   = 1'b1;
                end
                else
                begin
                    mstate_next = hit_rule.to_state;
                    sp_next     = sp_reg - 1'b1;
                end
            end
            BS_PUSH:
            begin
                // One push field per cycle; empty fields are skipped.
                k_next = k_reg + 2'd1;
                if (cur_push != NO_SYMBOL)
                begin
                    stk_we   = 1'b1;
                    top_next = cur_push;
                    sp_next  = sp_reg + 1'b1;
                end
            end
            BS_FILL:
            begin
                top_next = rd_reg;
            end
            BS_FINISH:
            begin
                if (cmd_reg.last)
                begin
                    status_next = STATUS_ACCEPT;
                    dead_next   = 1'b1;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            init_reg   <= '0;
            mstate_reg <= '0;
            sp_reg     <= '0;
            dead_reg   <= 1'b1;
            valid_reg  <= '0;
            status_reg <= STATUS_RUN;
        end
        else
        begin
            state_reg  <= state_next;
            mstate_reg <= mstate_next;
            sp_reg     <= sp_next;
            dead_reg   <= dead_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                init_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        top_reg     <= top_next;
        match_reg   <= match_next;
        hit_idx_reg <= hit_idx_next;
        hit_reg     <= hit_next;
        push_reg    <= push_next;
        k_reg       <= k_next;
    end

    // Transition table write port.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_reg[TBL_AW'(cmd_reg.entry_index)] <= cmd_reg.rule;
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        rd_reg <= stack_mem[stk_raddr];
    end

endmodule

### sv/pushdown_automaton_recognizer_top.sv
// Deterministic pushdown automaton. Items are taken whenever busy is low and
// land in a two-entry command queue; each item yields exactly one result,
// shown for one cycle while done is high, and the receiver cannot stall it.
// Load, start and unused items go straight from execution to the report in the
// back end, as does a symbol fed to a dead string or onto an empty stack. Any
// other fed symbol takes a registered table match, a priority pick and a bound
// check, which reports at once on a miss or overflow; else one push field per
// cycle through the single write port of the stack memory, or a registered read
// of the stack memory to restore the top when the transition pushes nothing.
// The sequencer works on one item at a time and takes the next only after the report.
`include "pushdown_automaton_recognizer_top_defines.svh"

module pushdown_automaton_recognizer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pda_pkg::item_t    item,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_data,
    output logic             done,
    output pda_pkg::result_t  result
);
    import pda_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t front_cmd;
    cmd_t head_cmd;

    // Conditions watched by the result checks.
    logic depth_zero;
    logic empty_report;
    logic empty_done;

    assign busy = q_full;

    // Front end: accept and classify items.
    pda_front u_front (
        .start  (start),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .cmd    (front_cmd)
    );

    // Command queue between front and back.
    pda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: table, stack and transition sequencer.
    pda_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .done     (done),
        .result   (result)
    );

    assign depth_zero   = (result.stack_depth == '0);
    assign empty_report = done && depth_zero;
    assign empty_done   = done && (result.status == STATUS_EMPTY);

    // Consistency checks on the reported results.
    `PDA_ASSERT_NEXT(a_single_report, done, !done, "result strobe lasted more than one cycle")
    `PDA_ASSERT_IMPLY(a_depth_bound, done, result.stack_depth <= STACK_DEPTH, "depth above bound")
    `PDA_ASSERT_IMPLY(a_empty_top, empty_report, result.stack_top == '0, "empty stack has a top")
    `PDA_ASSERT_IMPLY(a_empty_status, empty_done, depth_zero, "empty status with symbols on stack")

endmodule
